// ----- design/mecanum_wheel_mixer_limiter_assert.svh -----
// Assertion macros shared by the mixer/limiter RTL.
// Both macros expect signals named clk and rst_n in the enclosing scope.
`ifndef MECANUM_WHEEL_MIXER_LIMITER_ASSERT_SVH
`define MECANUM_WHEEL_MIXER_LIMITER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on that clock edge.
`define MWML_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mwml assertion failed");

// Next-cycle implication: when ante holds, cons must hold at the following clock edge.
`define MWML_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mwml assertion failed");

`endif

// ----- design/mwml_pkg.sv -----
package mwml_pkg;

  // Default width of the signed speed fields.
  localparam int unsigned SPEED_BITS_DEF = 16;

  // Width of the wheel speed limit register, and of the quotient it bounds.
  localparam int unsigned LIMIT_BITS = 15;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 15'd8000;

  localparam int unsigned NUM_WHEELS = 4;

endpackage

// ----- design/mwml_div.sv -----
module mwml_div #(
  parameter int unsigned NUM_BITS  = 32,
  parameter int unsigned DEN_BITS  = 17,
  parameter int unsigned QUOT_BITS = mwml_pkg::LIMIT_BITS
) (
  input  logic                 clk,
  input  logic [NUM_BITS-1:0]  num,
  input  logic [DEN_BITS-1:0]  den,
  output logic [QUOT_BITS-1:0] quot
);

  // Restoring division, one quotient bit per stage, MSB first.
  // The caller guarantees num < den * 2^QUOT_BITS.
  logic [NUM_BITS-1:0]  rem_r  [QUOT_BITS-1];
  logic [DEN_BITS-1:0]  den_r  [QUOT_BITS-1];
  logic [QUOT_BITS-1:0] quot_r [QUOT_BITS];

  genvar g;
  for (g = 0; g < QUOT_BITS; g++) begin : g_step
    logic [NUM_BITS-1:0]  rem_in;
    logic [DEN_BITS-1:0]  den_in;
    logic [QUOT_BITS-1:0] quot_in;
    logic [NUM_BITS-1:0]  trial;
    logic                 take;

    if (g == 0) begin : g_head
      assign rem_in  = num;
      assign den_in  = den;
      assign quot_in = '0;
    end else begin : g_body
      assign rem_in  = rem_r[g-1];
      assign den_in  = den_r[g-1];
      assign quot_in = quot_r[g-1];
    end

    assign trial = NUM_BITS'(den_in) << (QUOT_BITS - 1 - g);
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      quot_r[g] <= {quot_in[QUOT_BITS-2:0], take};
    end

    // The last stage only produces its quotient bit.
    if (g < QUOT_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[g] <= take ? (rem_in - trial) : rem_in;
        den_r[g] <= den_in;
      end
    end
  end

  assign quot = quot_r[QUOT_BITS-1];

endmodule

// ----- design/mecanum_wheel_mixer_limiter.sv -----
// Four-wheel mecanum mixer with proportional speed limiting.
// Input: a velocity command (in_forward_speed, in_sideways_speed, in_turn_speed)
// is transferred at a rising edge where start is high and busy is low. busy is
// always low: the datapath is a fully pipelined chain with no stall points, so
// a new command may be transferred on every clock cycle.
//
// Output: each result appears for exactly one cycle with out_valid high, and is
// transferred at the edge that ends that cycle. The receiver cannot stall, and
// no result is ever held back or dropped.
//
// The result passes through these registered stages in order: one stage each
// for the wheel sums, the magnitudes, and the maximum search plus limit
// multiply, fifteen one-bit restoring divider stages (one quotient bit per
// limit bit), and one output stage for sign and clamp.
// Throughput is one command per cycle.
//
// Configuration: cfg_we writes cfg_wdata into the wheel speed limit. The limit
// is captured with each command, so every result uses the limit in force when
// its command was transferred. Reset clears all valid bits and restores the
// limit to 8000 rpm.
`include "mecanum_wheel_mixer_limiter_assert.svh"

module mecanum_wheel_mixer_limiter #(
  parameter int unsigned SPEED_BITS = mwml_pkg::SPEED_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [SPEED_BITS-1:0]        in_forward_speed,
  input  logic signed [SPEED_BITS-1:0]        in_sideways_speed,
  input  logic signed [SPEED_BITS-1:0]        in_turn_speed,
  input  logic                                cfg_we,
  input  logic [mwml_pkg::LIMIT_BITS-1:0]     cfg_wdata,
  output logic                                out_valid,
  output logic signed [SPEED_BITS-1:0]        out_front_right_speed,
  output logic signed [SPEED_BITS-1:0]        out_front_left_speed,
  output logic signed [SPEED_BITS-1:0]        out_rear_left_speed,
  output logic signed [SPEED_BITS-1:0]        out_rear_right_speed,
  output logic                                out_was_scaled
);

  localparam int unsigned NW = mwml_pkg::NUM_WHEELS;
  localparam int unsigned LB = mwml_pkg::LIMIT_BITS;
  // Wheel sums of three signed terms need two extra bits.
  localparam int unsigned WB = SPEED_BITS + 2;
  // A wheel magnitude is at most 3 * 2^(SPEED_BITS-1).
  localparam int unsigned MB = SPEED_BITS + 1;
  // Common width for comparing magnitudes against the limit.
  localparam int unsigned CB = (MB > LB) ? MB : LB;
  // Signed width for the final select and clamp.
  localparam int unsigned RB = CB + 1;
  // Product of a magnitude and the limit.
  localparam int unsigned NB = MB + LB;
  // The scaled quotient never exceeds the limit, so it has LB bits.
  localparam int unsigned QB = LB;
  localparam int unsigned LATENCY = 4 + QB;

  localparam logic signed [RB-1:0] SAT_POS =
    RB'((64'sd1 <<< (SPEED_BITS - 1)) - 64'sd1);
  localparam logic signed [RB-1:0] SAT_NEG = -SAT_POS;

  typedef logic signed [WB-1:0] wsum_t;

  // Data that rides alongside the divider pipeline.
  typedef struct packed {
    logic                   scaled;
    logic [LB-1:0]          lim;
    logic [NW-1:0][WB-1:0]  w;
  } side_t;

  // The block never refuses a command.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------------
  logic [LB-1:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= mwml_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      lim_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: mecanum inverse kinematics. Wheel order is front right, front
  // left, rear left, rear right; the left side wheels take the forward term negated.
  // ---------------------------------------------------------------------------
  logic          a_vld_r;
  logic [LB-1:0] a_lim_r;
  wsum_t         a_w_r   [NW];
  wsum_t         a_w_nxt [NW];
  wsum_t         vx;
  wsum_t         vy;
  wsum_t         vw;

  always_comb begin
    vx = WB'(in_forward_speed);
    vy = WB'(in_sideways_speed);
    vw = WB'(in_turn_speed);
    a_w_nxt[0] = vx + vy + vw;
    a_w_nxt[1] = vy + vw - vx;
    a_w_nxt[2] = vw - vx - vy;
    a_w_nxt[3] = vx - vy + vw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_lim_r <= lim_r;
    for (int i = 0; i < NW; i++) begin
      a_w_r[i] <= a_w_nxt[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: wheel magnitudes.
  // ---------------------------------------------------------------------------
  logic          b_vld_r;
  logic [LB-1:0] b_lim_r;
  wsum_t         b_w_r     [NW];
  logic [MB-1:0] b_mag_r   [NW];
  logic [MB-1:0] b_mag_nxt [NW];
  wsum_t         abs_w     [NW];

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      abs_w[i]     = a_w_r[i][WB-1] ? -a_w_r[i] : a_w_r[i];
      b_mag_nxt[i] = abs_w[i][MB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_lim_r <= a_lim_r;
    for (int i = 0; i < NW; i++) begin
      b_w_r[i]   <= a_w_r[i];
      b_mag_r[i] <= b_mag_nxt[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: largest magnitude, the limit decision and the numerators
  // |w| * limit. The limit decision tests each wheel on its own, which is the
  // same as testing the largest one and keeps the compare off the max tree.
  // ---------------------------------------------------------------------------
  logic          c_vld_r;
  side_t         c_side_r;
  side_t         c_side_nxt;
  logic [NB-1:0] c_prod_r [NW];
  logic [MB-1:0] c_largest_r;
  logic [MB-1:0] c_largest_nxt;
  logic [MB-1:0] max01;
  logic [MB-1:0] max23;
  logic [NW-1:0] over;

  always_comb begin
    max01         = (b_mag_r[0] > b_mag_r[1]) ? b_mag_r[0] : b_mag_r[1];
    max23         = (b_mag_r[2] > b_mag_r[3]) ? b_mag_r[2] : b_mag_r[3];
    c_largest_nxt = (max01 > max23) ? max01 : max23;
    for (int i = 0; i < NW; i++) begin
      over[i]         = CB'(b_mag_r[i]) > CB'(b_lim_r);
      c_side_nxt.w[i] = b_w_r[i];
    end
    c_side_nxt.scaled = |over;
    c_side_nxt.lim    = b_lim_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c_side_r    <= c_side_nxt;
    c_largest_r <= c_largest_nxt;
    for (int i = 0; i < NW; i++) begin
      c_prod_r[i] <= NB'(b_mag_r[i]) * NB'(b_lim_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Divider pipelines, one per wheel, all sharing the same divisor. The side
  // data is delayed by the same number of stages.
  // ---------------------------------------------------------------------------
  logic [QB-1:0] quot     [NW];
  logic          d_vld_r  [QB];
  side_t         d_side_r [QB];

  genvar gw;
  for (gw = 0; gw < NW; gw++) begin : g_lane
    mwml_div #(
      .NUM_BITS  (NB),
      .DEN_BITS  (MB),
      .QUOT_BITS (QB)
    ) u_div (
      .clk  (clk),
      .num  (c_prod_r[gw]),
      .den  (c_largest_r),
      .quot (quot[gw])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QB; k++) begin
        d_vld_r[k] <= 1'b0;
      end
    end else begin
      d_vld_r[0] <= c_vld_r;
      for (int k = 1; k < QB; k++) begin
        d_vld_r[k] <= d_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    d_side_r[0] <= c_side_r;
    for (int k = 1; k < QB; k++) begin
      d_side_r[k] <= d_side_r[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: restore the sign of the quotient (giving truncation toward
  // zero), pass the raw sum through when no limiting applies, and clamp to
  // the symmetric range of the output field.
  // ---------------------------------------------------------------------------
  side_t                        tail;
  logic signed [RB-1:0]         w_ext   [NW];
  logic        [RB-1:0]         q_ext   [NW];
  logic signed [RB-1:0]         pick    [NW];
  logic signed [SPEED_BITS-1:0] out_speed_nxt [NW];
  logic signed [SPEED_BITS-1:0] out_speed_r   [NW];
  logic                         out_vld_r;
  logic                         out_scaled_r;
  logic        [LB-1:0]         out_lim_r;

  always_comb begin
    tail = d_side_r[QB-1];
    for (int i = 0; i < NW; i++) begin
      w_ext[i] = RB'($signed(tail.w[i]));
      q_ext[i] = RB'(quot[i]);
      if (!tail.scaled) begin
        pick[i] = w_ext[i];
      end else if (w_ext[i] < 0) begin
        pick[i] = -$signed(q_ext[i]);
      end else begin
        pick[i] = $signed(q_ext[i]);
      end
      if (pick[i] > SAT_POS) begin
        out_speed_nxt[i] = SAT_POS[SPEED_BITS-1:0];
      end else if (pick[i] < SAT_NEG) begin
        out_speed_nxt[i] = SAT_NEG[SPEED_BITS-1:0];
      end else begin
        out_speed_nxt[i] = pick[i][SPEED_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= d_vld_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    out_scaled_r <= tail.scaled;
    out_lim_r    <= tail.lim;
    for (int i = 0; i < NW; i++) begin
      out_speed_r[i] <= out_speed_nxt[i];
    end
  end

  assign out_valid             = out_vld_r;
  assign out_front_right_speed = out_speed_r[0];
  assign out_front_left_speed  = out_speed_r[1];
  assign out_rear_left_speed   = out_speed_r[2];
  assign out_rear_right_speed  = out_speed_r[3];
  assign out_was_scaled        = out_scaled_r;

  // ---------------------------------------------------------------------------
  // Checks. Every delivered wheel speed must stay within the limit its command
  // saw, whether it was scaled or passed through.
  // ---------------------------------------------------------------------------
  logic [SPEED_BITS:0] out_abs    [NW];
  logic [NW-1:0]       out_within;
  logic                out_all_zero;

  always_comb begin
    out_all_zero = 1'b1;
    for (int i = 0; i < NW; i++) begin
      out_abs[i]    = out_speed_r[i][SPEED_BITS-1] ?
                      (SPEED_BITS+1)'(-$signed({out_speed_r[i][SPEED_BITS-1],
                                                out_speed_r[i]})) :
                      (SPEED_BITS+1)'(out_speed_r[i]);
      out_within[i] = CB'(out_abs[i]) <= CB'(out_lim_r);
      if (out_speed_r[i] != '0) begin
        out_all_zero = 1'b0;
      end
    end
  end

  `MWML_ASSERT_NEXT(a_cmd_enters, start && !busy, a_vld_r)
  `MWML_ASSERT_IMP(a_result_has_cmd, out_vld_r, $past(start, LATENCY))
  `MWML_ASSERT_IMP(a_scaled_above_limit, c_vld_r && c_side_r.scaled,
    CB'(c_largest_r) > CB'(c_side_r.lim))
  `MWML_ASSERT_IMP(a_within_limit, out_vld_r, &out_within)
  `MWML_ASSERT_IMP(a_zero_limit_stops, out_vld_r && (out_lim_r == '0), out_all_zero)

endmodule
